// File: rtl/core/php_pkg.sv
package php_pkg;

	typedef enum logic [15:0] {
		PH_SYNC      = 16'h0001,
		PH_LEN_HI    = 16'h0002,
		PH_LEN_LO    = 16'h0004,
		PH_M1_FIRST  = 16'h0008,
		PH_M1_STD2   = 16'h0010,
		PH_M1_AFTER  = 16'h0020,
		PH_M2_FLAGS2 = 16'h0040,
		PH_M2_HDL    = 16'h0080,
		PH_TS        = 16'h0100,
		PH_SKIPN     = 16'h0200,
		PH_EXT_FLAGS = 16'h0400,
		PH_PACK_LEN  = 16'h0800,
		PH_EXT2_LEN  = 16'h1000,
		PH_HDR_PAD   = 16'h2000,
		PH_PAYLOAD   = 16'h4000,
		PH_SKIPPING  = 16'h8000
	} phase_t;

	typedef enum logic [1:0] {
		RC_CONT = 2'd0,
		RC_DONE = 2'd1,
		RC_LOST = 2'd2
	} rc_t;

	localparam logic [2:0] EV_SEARCH  = 3'd0;
	localparam logic [2:0] EV_HEADER  = 3'd1;
	localparam logic [2:0] EV_PAYLOAD = 3'd2;
	localparam logic [2:0] EV_SKIPPED = 3'd3;
	localparam logic [2:0] EV_DONE    = 3'd4;
	localparam logic [2:0] EV_LOST    = 3'd5;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] window;
		logic [15:0] packet_left;
		logic [7:0]  header_left;
		logic [2:0]  field_index;
		logic [7:0]  header_flags;
		logic [7:0]  ext_flags;
		logic [39:0] time_shift;
		logic [32:0] pts_hold;
		logic [32:0] dts_hold;
		logic        pts_seen;
		logic        dts_seen;
		logic        unbounded;
		logic        first_pending;
		logic [7:0]  current_id;
	} state_t;

	typedef struct packed {
		state_t st;
		rc_t    rc;
	} seg_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [7:0] payload_byte;
		logic       first_of_packet;
	} res_t;

endpackage

// File: rtl/core/php_step.sv
module php_step
	import php_pkg::*;
(
	input  state_t     st,
	input  logic       zero_len_open,
	input  logic       action,
	input  logic [7:0] data_byte,
	output state_t     nst,
	output res_t       res
);

	function automatic seg_t enter_phase(input state_t s, input phase_t ph, input logic [7:0] need);
		seg_t o;
		o.st = s;
		o.rc = RC_CONT;
		if (s.header_left < need) o.rc = RC_LOST;
		else o.st.phase = ph;
		return o;
	endfunction

	function automatic seg_t enter_skip(input state_t s, input logic [7:0] count);
		seg_t o;
		o.st = s;
		o.rc = RC_CONT;
		if (s.header_left < count) begin
			o.rc = RC_LOST;
		end else begin
			o.st.time_shift = {32'd0, count};
			o.st.phase = PH_SKIPN;
		end
		return o;
	endfunction

	function automatic seg_t next_segment(input state_t s);
		seg_t   o;
		state_t t;
		t = s;
		o.st = s;
		o.rc = RC_CONT;
		if ((t.header_flags & 8'hC0) != 8'h00) begin
			t.field_index = 3'd0;
			t.time_shift = 40'd0;
			o = enter_phase(t, PH_TS, 8'd5);
		end else if (t.header_flags[5]) begin
			t.header_flags[5] = 1'b0;
			o = enter_skip(t, 8'd6);
		end else if (t.header_flags[4]) begin
			t.header_flags[4] = 1'b0;
			o = enter_skip(t, 8'd3);
		end else if (t.header_flags[3]) begin
			t.header_flags[3] = 1'b0;
			o = enter_skip(t, 8'd1);
		end else if (t.header_flags[2]) begin
			t.header_flags[2] = 1'b0;
			o = enter_skip(t, 8'd1);
		end else if (t.header_flags[1]) begin
			t.header_flags[1] = 1'b0;
			o = enter_skip(t, 8'd2);
		end else if (t.header_flags[0]) begin
			t.header_flags[0] = 1'b0;
			o = enter_phase(t, PH_EXT_FLAGS, 8'd1);
		end else if (t.ext_flags[7]) begin
			t.ext_flags[7] = 1'b0;
			o = enter_skip(t, 8'd16);
		end else if (t.ext_flags[6]) begin
			t.ext_flags[6] = 1'b0;
			o = enter_phase(t, PH_PACK_LEN, 8'd1);
		end else if (t.ext_flags[5]) begin
			t.ext_flags[5] = 1'b0;
			o = enter_skip(t, 8'd2);
		end else if (t.ext_flags[4]) begin
			t.ext_flags[4] = 1'b0;
			o = enter_skip(t, 8'd2);
		end else if (t.ext_flags[0]) begin
			t.ext_flags[0] = 1'b0;
			o = enter_phase(t, PH_EXT2_LEN, 8'd1);
		end else if (t.header_left != 8'd0) begin
			t.phase = PH_HDR_PAD;
			o.st = t;
		end else begin
			o.rc = RC_DONE;
		end
		return o;
	endfunction

	function automatic seg_t ts_byte(input state_t s, input logic [7:0] b);
		seg_t        o;
		state_t      t;
		logic [32:0] v;
		t = s;
		o.st = s;
		o.rc = RC_CONT;
		if (t.header_left != 8'd0) t.header_left = t.header_left - 8'd1;
		if ((t.field_index == 3'd0 || t.field_index == 3'd2 || t.field_index == 3'd4)
				&& !b[0]) begin
			o.st = t;
			o.rc = RC_LOST;
		end else begin
			t.time_shift = {t.time_shift[31:0], b};
			if (t.field_index < 3'd4) begin
				t.field_index = t.field_index + 3'd1;
				o.st = t;
			end else begin
				t.field_index = 3'd0;
				v = {t.time_shift[35:33], t.time_shift[31:24], t.time_shift[23:17],
					t.time_shift[15:8], t.time_shift[7:1]};
				if (t.header_flags[7]) begin
					t.pts_hold = v;
					t.pts_seen = 1'b1;
					t.header_flags[7] = 1'b0;
				end else begin
					t.dts_hold = v;
					t.dts_seen = 1'b1;
					t.header_flags[6] = 1'b0;
				end
				o = next_segment(t);
			end
		end
		return o;
	endfunction

	function automatic seg_t m1_flags(input state_t s, input logic [7:0] b);
		seg_t   o;
		state_t t;
		t = s;
		o.st = s;
		o.rc = RC_CONT;
		if (b[7:4] == 4'h2 || b[7:4] == 4'h3) begin
			t.header_flags = (b[7:4] == 4'h2) ? 8'h80 : 8'hC0;
			t.header_left = (b[7:4] == 4'h2) ? 8'd5 : 8'd10;
			t.ext_flags = 8'h00;
			t.field_index = 3'd0;
			t.time_shift = 40'd0;
			t.phase = PH_TS;
			o = ts_byte(t, b);
		end else if (b[7:6] == 2'b10) begin
			t.phase = PH_M2_FLAGS2;
			o.st = t;
		end else if (b == 8'h0F) begin
			o.rc = RC_DONE;
		end else begin
			o.rc = RC_LOST;
		end
		return o;
	endfunction

	function automatic seg_t header_byte(input state_t s, input logic [7:0] b);
		seg_t       o;
		state_t     t;
		logic [7:0] n;
		t = s;
		o.st = s;
		o.rc = RC_CONT;
		n = 8'd0;
		case (t.phase)
			PH_M1_FIRST: begin
				if (b == 8'hFF) begin
					o.rc = RC_CONT;
				end else if (b[7:6] == 2'b01) begin
					o.st.phase = PH_M1_STD2;
				end else begin
					o = m1_flags(t, b);
				end
			end
			PH_M1_STD2: o.st.phase = PH_M1_AFTER;
			PH_M1_AFTER: o = m1_flags(t, b);
			PH_M2_FLAGS2: begin
				o.st.header_flags = b;
				o.st.ext_flags = 8'h00;
				o.st.phase = PH_M2_HDL;
			end
			PH_M2_HDL: begin
				t.header_left = b;
				o.st = t;
				if (!t.unbounded && {8'd0, b} > t.packet_left) o.rc = RC_LOST;
				else if (t.header_flags[7:6] == 2'b01) o.rc = RC_LOST;
				else o = next_segment(t);
			end
			PH_TS: o = ts_byte(t, b);
			PH_SKIPN: begin
				if (t.header_left != 8'd0) t.header_left = t.header_left - 8'd1;
				if (t.time_shift != 40'd0) t.time_shift = t.time_shift - 40'd1;
				o.st = t;
				if (t.time_shift == 40'd0) o = next_segment(t);
			end
			PH_EXT_FLAGS: begin
				if (t.header_left != 8'd0) t.header_left = t.header_left - 8'd1;
				t.ext_flags = b & 8'hF1;
				o = next_segment(t);
			end
			PH_PACK_LEN, PH_EXT2_LEN: begin
				if (t.header_left != 8'd0) t.header_left = t.header_left - 8'd1;
				n = (t.phase == PH_PACK_LEN) ? b : (b & 8'h7F);
				o.st = t;
				if (n == 8'd0) o = next_segment(t);
				else o = enter_skip(t, n);
			end
			default: begin
				if (t.header_left != 8'd0) t.header_left = t.header_left - 8'd1;
				o.st = t;
				o.rc = (t.header_left == 8'd0) ? RC_DONE : RC_CONT;
			end
		endcase
		return o;
	endfunction

	function automatic logic is_start(input logic [31:0] w);
		return ((w & 32'hFFFFFFFC) == 32'h000001BC) ||
			((w & 32'hFFFFFFFD) == 32'h000001BD) ||
			((w & 32'hFFFFFFE0) == 32'h000001C0) ||
			((w & 32'hFFFFFFF0) == 32'h000001F0) ||
			((w & 32'hFFFFFFF0) == 32'h000001E0);
	endfunction

	function automatic state_t finish_header(input state_t s);
		state_t t;
		t = s;
		t.first_pending = 1'b1;
		t.window = '1;
		t.phase = (t.unbounded || t.packet_left != 16'd0) ? PH_PAYLOAD : PH_SYNC;
		return t;
	endfunction

	logic [31:0] win;
	logic [7:0]  id;
	seg_t        hb;
	state_t      hs;

	always_comb begin
		nst = st;
		res = '0;
		win = {st.window[23:0], data_byte};
		id = st.current_id;
		hs = st;
		hb = '0;
		if (action) begin
			nst.phase = PH_SYNC;
			nst.window = '1;
		end else begin
			case (st.phase)
				PH_LEN_HI: begin
					nst.packet_left = {data_byte, 8'h00};
					nst.phase = PH_LEN_LO;
					res.event_res = EV_HEADER;
				end
				PH_LEN_LO: begin
					nst.packet_left = {st.packet_left[15:8], data_byte};
					nst.unbounded = (nst.packet_left == 16'd0) &&
						(id[7:4] == 4'hE || id == 8'hFD || zero_len_open);
					if (id == 8'hBC || id == 8'hBF || id == 8'hF0 || id == 8'hF1 ||
							id == 8'hF2 || id == 8'hF8 || id == 8'hFF) begin
						nst = finish_header(nst);
						res.event_res = EV_DONE;
					end else if (id == 8'hBE) begin
						nst.window = '1;
						nst.phase = (nst.unbounded || nst.packet_left != 16'd0) ?
							PH_SKIPPING : PH_SYNC;
						res.event_res = EV_DONE;
					end else if (!nst.unbounded && nst.packet_left == 16'd0) begin
						nst.phase = PH_SYNC;
						nst.window = '1;
						res.event_res = EV_LOST;
					end else begin
						nst.pts_hold = '0;
						nst.dts_hold = '0;
						nst.pts_seen = 1'b0;
						nst.dts_seen = 1'b0;
						nst.phase = PH_M1_FIRST;
						res.event_res = EV_HEADER;
					end
				end
				PH_PAYLOAD, PH_SKIPPING: begin
					if (st.phase == PH_PAYLOAD) begin
						res.event_res = EV_PAYLOAD;
						res.payload_byte = data_byte;
						res.first_of_packet = st.first_pending;
						nst.first_pending = 1'b0;
					end else begin
						res.event_res = EV_SKIPPED;
					end
					if (!st.unbounded) begin
						if (st.packet_left != 16'd0) nst.packet_left = st.packet_left - 16'd1;
						if (nst.packet_left == 16'd0) begin
							nst.phase = PH_SYNC;
							nst.window = '1;
						end
					end
				end
				PH_M1_FIRST, PH_M1_STD2, PH_M1_AFTER, PH_M2_FLAGS2, PH_M2_HDL, PH_TS,
				PH_SKIPN, PH_EXT_FLAGS, PH_PACK_LEN, PH_EXT2_LEN, PH_HDR_PAD: begin
					if (!st.unbounded && st.packet_left != 16'd0)
						hs.packet_left = st.packet_left - 16'd1;
					hb = header_byte(hs, data_byte);
					nst = hb.st;
					if (hb.rc == RC_LOST) begin
						nst.phase = PH_SYNC;
						nst.window = '1;
						res.event_res = EV_LOST;
					end else if (hb.rc == RC_DONE) begin
						nst = finish_header(nst);
						res.event_res = EV_DONE;
					end else if (!nst.unbounded && nst.packet_left == 16'd0) begin
						nst.phase = PH_SYNC;
						nst.window = '1;
						res.event_res = EV_LOST;
					end else begin
						res.event_res = EV_HEADER;
					end
				end
				default: begin
					nst.phase = PH_SYNC;
					nst.window = win;
					if (is_start(win)) begin
						nst.current_id = data_byte;
						nst.window = '1;
						nst.phase = PH_LEN_HI;
						res.event_res = EV_HEADER;
					end
				end
			endcase
		end
	end

endmodule

// File: rtl/core/pes_header_parser.sv
// channel   | valid     | stall     | payload
// input     | in_valid  | in_stall  | action, data_byte
// output    | out_valid | out_stall | event_res .. bytes_left
// config    | cfg_we    | -         | cfg_wdata (zero length opens any id)
// one byte per clock sustained while the result is not stalled; the result is registered
// stage s1 holds the byte, the parse step runs between s1 and the result register
// arst_n clears the parser state, the stage valids and the config bit
// a stalled result holds s1, and s1 full under a stall raises in_stall
module pes_header_parser
	import php_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [7:0]  payload_byte,
	output logic        first_of_packet,
	output logic [7:0]  stream_id,
	output logic [32:0] pts,
	output logic        pts_valid,
	output logic [32:0] dts,
	output logic        dts_valid,
	output logic [15:0] bytes_left
);

	logic       allow_q;
	logic       valid_s1;
	logic       action_s1;
	logic [7:0] byte_s1;
	logic       adv;
	state_t     st_q;
	state_t     nst;
	res_t       res;

	assign adv = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !adv;

	php_step u_step (
		.st              (st_q),
		.zero_len_open   (allow_q),
		.action          (action_s1),
		.data_byte       (byte_s1),
		.nst             (nst),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q <= 1'b0;
		end else if (cfg_we) begin
			allow_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			action_s1 <= action;
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_SYNC, window: '1, first_pending: 1'b1, default: '0};
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1;
			if (valid_s1) st_q <= nst;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			event_res <= res.event_res;
			payload_byte <= res.payload_byte;
			first_of_packet <= res.first_of_packet;
			stream_id <= nst.current_id;
			pts <= nst.pts_hold;
			pts_valid <= nst.pts_seen;
			dts <= nst.dts_hold;
			dts_valid <= nst.dts_seen;
			bytes_left <= nst.packet_left;
		end
	end

	a_first_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_of_packet |-> event_res == EV_PAYLOAD)
		else $error("first mark off payload");

	a_byte_only_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_PAYLOAD |-> payload_byte == 8'd0)
		else $error("payload byte outside payload");

	a_pts_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pts_valid |-> pts == 33'd0)
		else $error("stale pts");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1))
		else $error("s1 lost under stall");

	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_res <= EV_LOST)
		else $error("bad event code");

endmodule

// File: bench/pes_header_checker.sv
module pes_header_checker
	import php_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        action,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  event_res,
	input  logic [7:0]  payload_byte,
	input  logic        first_of_packet,
	input  logic [7:0]  stream_id,
	input  logic [32:0] pts,
	input  logic        pts_valid,
	input  logic [32:0] dts,
	input  logic        dts_valid,
	input  logic [15:0] bytes_left,
	output int          fail_count,
	output int          pending,
	output int          n_payload,
	output int          n_header_done,
	output int          n_lost,
	output int          n_skipped
);

	typedef struct packed {
		logic [2:0]  ev;
		logic [7:0]  pay;
		logic        first;
		logic [7:0]  sid;
		logic [32:0] pts;
		logic        pv;
		logic [32:0] dts;
		logic        dv;
		logic [15:0] left;
	} parse_out_t;

	parse_out_t expected_q[$];

	logic        unb_cfg;
	phase_t      ph;
	logic [31:0] win;
	logic [15:0] pkt_left;
	logic [7:0]  hdr_left;
	logic [4:0]  fidx;
	logic [7:0]  hflags;
	logic [7:0]  xflags;
	logic [39:0] tshift;
	logic [32:0] pts_h;
	logic [32:0] dts_h;
	logic        pts_s;
	logic        dts_s;
	logic        unb;
	logic        first_p;
	logic [7:0]  cur_id;

	function automatic logic sync_match(logic [31:0] w);
		return ((w & 32'hfffffffc) == 32'h000001bc) ||
			((w & 32'hfffffffd) == 32'h000001bd) ||
			((w & 32'hffffffe0) == 32'h000001c0) ||
			((w & 32'hfffffff0) == 32'h000001f0) ||
			((w & 32'hfffffff0) == 32'h000001e0);
	endfunction

	function automatic rc_t go_phase(phase_t p, int need);
		if (hdr_left < need)
			return RC_LOST;
		ph = p;
		return RC_CONT;
	endfunction

	function automatic rc_t go_skip(int count);
		if (hdr_left < count)
			return RC_LOST;
		tshift = 40'(count);
		ph = PH_SKIPN;
		return RC_CONT;
	endfunction

	function automatic rc_t next_field();
		if (hflags & 8'hc0) begin
			fidx = 0;
			tshift = 0;
			return go_phase(PH_TS, 5);
		end
		if (hflags[5]) begin hflags[5] = 0; return go_skip(6); end
		if (hflags[4]) begin hflags[4] = 0; return go_skip(3); end
		if (hflags[3]) begin hflags[3] = 0; return go_skip(1); end
		if (hflags[2]) begin hflags[2] = 0; return go_skip(1); end
		if (hflags[1]) begin hflags[1] = 0; return go_skip(2); end
		if (hflags[0]) begin hflags[0] = 0; return go_phase(PH_EXT_FLAGS, 1); end
		if (xflags[7]) begin xflags[7] = 0; return go_skip(16); end
		if (xflags[6]) begin xflags[6] = 0; return go_phase(PH_PACK_LEN, 1); end
		if (xflags[5]) begin xflags[5] = 0; return go_skip(2); end
		if (xflags[4]) begin xflags[4] = 0; return go_skip(2); end
		if (xflags[0]) begin xflags[0] = 0; return go_phase(PH_EXT2_LEN, 1); end
		if (hdr_left > 0) begin
			ph = PH_HDR_PAD;
			return RC_CONT;
		end
		return RC_DONE;
	endfunction

	function automatic rc_t stamp_byte(logic [7:0] b);
		logic [39:0] t;
		logic [32:0] v;
		if (hdr_left > 0)
			hdr_left--;
		if ((fidx == 0 || fidx == 2 || fidx == 4) && !b[0])
			return RC_LOST;
		tshift = {tshift[31:0], b};
		if (fidx < 4) begin
			fidx++;
			return RC_CONT;
		end
		fidx = 0;
		t = tshift;
		v = {t[35:33], t[31:24], t[23:17], t[15:8], t[7:1]};
		if (hflags[7]) begin
			pts_h = v;
			pts_s = 1;
			hflags[7] = 0;
		end else begin
			dts_h = v;
			dts_s = 1;
			hflags[6] = 0;
		end
		return next_field();
	endfunction

	function automatic rc_t mpeg1_flags(logic [7:0] b);
		if (b[7:4] == 4'h2 || b[7:4] == 4'h3) begin
			hflags = (b[7:4] == 4'h2) ? 8'h80 : 8'hc0;
			hdr_left = (b[7:4] == 4'h2) ? 8'd5 : 8'd10;
			xflags = 0;
			fidx = 0;
			tshift = 0;
			ph = PH_TS;
			return stamp_byte(b);
		end
		if (b[7:6] == 2'b10) begin
			ph = PH_M2_FLAGS2;
			return RC_CONT;
		end
		if (b == 8'h0f)
			return RC_DONE;
		return RC_LOST;
	endfunction

	function automatic rc_t parse_header_byte(logic [7:0] b);
		logic [7:0] n;
		case (ph)
			PH_M1_FIRST: begin
				if (b == 8'hff)
					return RC_CONT;
				if (b[7:6] == 2'b01) begin
					ph = PH_M1_STD2;
					return RC_CONT;
				end
				return mpeg1_flags(b);
			end
			PH_M1_STD2: begin
				ph = PH_M1_AFTER;
				return RC_CONT;
			end
			PH_M1_AFTER: return mpeg1_flags(b);
			PH_M2_FLAGS2: begin
				hflags = b;
				xflags = 0;
				ph = PH_M2_HDL;
				return RC_CONT;
			end
			PH_M2_HDL: begin
				hdr_left = b;
				if (!unb && b > pkt_left)
					return RC_LOST;
				if (hflags[7:6] == 2'b01)
					return RC_LOST;
				return next_field();
			end
			PH_TS: return stamp_byte(b);
			PH_SKIPN: begin
				if (hdr_left > 0)
					hdr_left--;
				if (tshift > 0)
					tshift--;
				if (tshift == 0)
					return next_field();
				return RC_CONT;
			end
			PH_EXT_FLAGS: begin
				if (hdr_left > 0)
					hdr_left--;
				xflags = b & 8'hf1;
				return next_field();
			end
			PH_PACK_LEN, PH_EXT2_LEN: begin
				if (hdr_left > 0)
					hdr_left--;
				n = (ph == PH_PACK_LEN) ? b : (b & 8'h7f);
				if (n == 0)
					return next_field();
				return go_skip(n);
			end
			default: begin
				if (hdr_left > 0)
					hdr_left--;
				return (hdr_left == 0) ? RC_DONE : RC_CONT;
			end
		endcase
	endfunction

	function automatic void hunt_again();
		ph = PH_SYNC;
		win = '1;
	endfunction

	function automatic void header_complete();
		first_p = 1;
		win = '1;
		ph = (unb || pkt_left > 0) ? PH_PAYLOAD : PH_SYNC;
	endfunction

	function automatic parse_out_t parse_byte(logic act, logic [7:0] b);
		parse_out_t o;
		rc_t r;
		o = '0;
		o.ev = EV_SEARCH;
		if (act) begin
			hunt_again();
		end else if (ph == PH_SYNC) begin
			win = {win[23:0], b};
			if (sync_match(win)) begin
				cur_id = b;
				win = '1;
				ph = PH_LEN_HI;
				o.ev = EV_HEADER;
			end
		end else if (ph == PH_LEN_HI) begin
			pkt_left = {b, 8'h00};
			ph = PH_LEN_LO;
			o.ev = EV_HEADER;
		end else if (ph == PH_LEN_LO) begin
			pkt_left[7:0] = b;
			unb = (pkt_left == 0 && (cur_id[7:4] == 4'he || cur_id == 8'hfd || unb_cfg));
			if (cur_id inside {8'hbc, 8'hbf, 8'hf0, 8'hf1, 8'hf2, 8'hf8, 8'hff}) begin
				header_complete();
				o.ev = EV_DONE;
			end else if (cur_id == 8'hbe) begin
				win = '1;
				ph = (unb || pkt_left > 0) ? PH_SKIPPING : PH_SYNC;
				o.ev = EV_DONE;
			end else if (!unb && pkt_left == 0) begin
				hunt_again();
				o.ev = EV_LOST;
			end else begin
				pts_h = 0;
				dts_h = 0;
				pts_s = 0;
				dts_s = 0;
				ph = PH_M1_FIRST;
				o.ev = EV_HEADER;
			end
		end else if (ph == PH_PAYLOAD || ph == PH_SKIPPING) begin
			if (ph == PH_PAYLOAD) begin
				o.ev = EV_PAYLOAD;
				o.pay = b;
				o.first = first_p;
				first_p = 0;
			end else begin
				o.ev = EV_SKIPPED;
			end
			if (!unb) begin
				if (pkt_left > 0)
					pkt_left--;
				if (pkt_left == 0)
					hunt_again();
			end
		end else begin
			if (!unb && pkt_left > 0)
				pkt_left--;
			r = parse_header_byte(b);
			if (r == RC_LOST) begin
				hunt_again();
				o.ev = EV_LOST;
			end else if (r == RC_DONE) begin
				header_complete();
				o.ev = EV_DONE;
			end else if (!unb && pkt_left == 0) begin
				hunt_again();
				o.ev = EV_LOST;
			end else begin
				o.ev = EV_HEADER;
			end
		end
		o.sid = cur_id;
		o.pts = pts_h;
		o.pv = pts_s;
		o.dts = dts_h;
		o.dv = dts_s;
		o.left = pkt_left;
		return o;
	endfunction

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		parse_out_t e;
		if (!arst_n) begin
			unb_cfg = 0;
			ph = PH_SYNC;
			win = '1;
			pkt_left = 0;
			hdr_left = 0;
			fidx = 0;
			hflags = 0;
			xflags = 0;
			tshift = 0;
			pts_h = 0;
			dts_h = 0;
			pts_s = 0;
			dts_s = 0;
			unb = 0;
			first_p = 1;
			cur_id = 0;
			expected_q.delete();
			fail_count = 0;
			pending = 0;
			n_payload = 0;
			n_header_done = 0;
			n_lost = 0;
			n_skipped = 0;
		end else begin
			if (cfg_we)
				unb_cfg = cfg_wdata;
			if (in_valid && !in_stall)
				expected_q.push_back(parse_byte(action, data_byte));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result, event %0d", $time, event_res);
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					compare_field("event_res", e.ev, event_res);
					compare_field("payload_byte", e.pay, payload_byte);
					compare_field("first_of_packet", e.first, first_of_packet);
					compare_field("stream_id", e.sid, stream_id);
					compare_field("pts", e.pts, pts);
					compare_field("pts_valid", e.pv, pts_valid);
					compare_field("dts", e.dts, dts);
					compare_field("dts_valid", e.dv, dts_valid);
					compare_field("bytes_left", e.left, bytes_left);
					case (e.ev)
						EV_PAYLOAD: n_payload++;
						EV_DONE:    n_header_done++;
						EV_LOST:    n_lost++;
						EV_SKIPPED: n_skipped++;
						default: ;
					endcase
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

// File: bench/pes_header_parser_tb.sv
module pes_header_parser_tb;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic        cfg_wdata = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        action = 0;
	logic [7:0]  data_byte = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  event_res;
	logic [7:0]  payload_byte;
	logic        first_of_packet;
	logic [7:0]  stream_id;
	logic [32:0] pts;
	logic        pts_valid;
	logic [32:0] dts;
	logic        dts_valid;
	logic [15:0] bytes_left;
	int          fail_count, pending, n_payload, n_header_done, n_lost, n_skipped;
	int          cycles = 0;
	int          sent = 0;
	logic        quiet = 0;
	logic [7:0]  pkt[$];

	localparam int CYCLE_LIMIT = 400000;

	pes_header_parser dut (.*);
	pes_header_checker chk (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver stalls in bursts
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 19);
				out_stall <= 1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 0;
		end
	end

	task automatic send_byte(logic act, logic [7:0] b);
		int n;
		if (!quiet && $urandom_range(0, 11) == 0) begin
			n = $urandom_range(1, 19);
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		action <= act;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic send_packet();
		foreach (pkt[i])
			send_byte(0, pkt[i]);
		pkt.delete();
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_cfg(logic v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic void add_start(logic [7:0] id, logic [15:0] len);
		pkt.push_back(8'h00);
		pkt.push_back(8'h00);
		pkt.push_back(8'h01);
		pkt.push_back(id);
		pkt.push_back(len[15:8]);
		pkt.push_back(len[7:0]);
	endfunction

	function automatic void add_stamp_q(ref logic [7:0] q[$], input logic [3:0] pfx);
		logic [32:0] v;
		v = {1'($urandom_range(0, 1)), $urandom()};
		q.push_back({pfx, v[32:30], 1'b1});
		q.push_back(v[29:22]);
		q.push_back({v[21:15], ($urandom_range(0, 15) != 0) ? 1'b1 : 1'b0});
		q.push_back(v[14:7]);
		q.push_back({v[6:0], 1'b1});
	endfunction

	// MPEG-2 style packet with random optional fields
	function automatic void build_mpeg2(logic [7:0] id, int body, logic good);
		logic [7:0] fl, xf;
		int hl, i;
		logic [7:0] hdr[$];
		logic [32:0] p, d;
		fl = 8'($urandom());
		if (good && fl[7:6] == 2'b01)
			fl[7] = 1;
		if ($urandom_range(0, 2) != 0)
			fl[5:1] = 0;
		p = {1'($urandom_range(0, 1)), $urandom()};
		d = {1'($urandom_range(0, 1)), $urandom()};
		if (fl[7]) begin
			hdr.push_back({fl[6] ? 4'h3 : 4'h2, p[32:30], 1'b1});
			hdr.push_back(p[29:22]); hdr.push_back({p[21:15], 1'b1});
			hdr.push_back(p[14:7]); hdr.push_back({p[6:0], 1'b1});
		end
		if (fl[6]) begin
			hdr.push_back({4'h1, d[32:30], 1'b1});
			hdr.push_back(d[29:22]); hdr.push_back({d[21:15], 1'b1});
			hdr.push_back(d[14:7]); hdr.push_back({d[6:0], 1'b1});
		end
		repeat ((fl[5] ? 6 : 0) + (fl[4] ? 3 : 0) + (fl[3] ? 1 : 0) + (fl[2] ? 1 : 0)
			+ (fl[1] ? 2 : 0))
			hdr.push_back(8'($urandom()));
		if (fl[0]) begin
			xf = 8'($urandom());
			hdr.push_back(xf);
			if (xf[7]) repeat (16) hdr.push_back(8'($urandom()));
			if (xf[6]) begin
				i = $urandom_range(0, 3);
				hdr.push_back(8'(i));
				repeat (i) hdr.push_back(8'($urandom()));
			end
			if (xf[5]) repeat (2) hdr.push_back(8'($urandom()));
			if (xf[4]) repeat (2) hdr.push_back(8'($urandom()));
			if (xf[0]) begin
				i = $urandom_range(0, 3);
				hdr.push_back({$urandom_range(0, 1) ? 1'b1 : 1'b0, 7'(i)});
				repeat (i) hdr.push_back(8'($urandom()));
			end
		end
		repeat ($urandom_range(0, 2)) hdr.push_back(8'hff);
		hl = hdr.size();
		if (!good && $urandom_range(0, 1))
			hl = $urandom_range(0, 255);
		add_start(id, 16'(3 + hdr.size() + body));
		pkt.push_back(8'h80 | (8'($urandom()) & 8'h3f));
		pkt.push_back(fl);
		pkt.push_back(8'(hl));
		foreach (hdr[k]) pkt.push_back(hdr[k]);
		repeat (body) pkt.push_back(8'($urandom()));
	endfunction

	function automatic void build_mpeg1(logic [7:0] id, int body);
		int n, hlen;
		logic [7:0] hdr[$];
		n = $urandom_range(0, 3);
		repeat (n) hdr.push_back(8'hff);
		if ($urandom_range(0, 1)) begin
			hdr.push_back(8'h40 | (8'($urandom()) & 8'h3f));
			hdr.push_back(8'($urandom()));
		end
		case ($urandom_range(0, 3))
			0: hdr.push_back(8'h0f);
			1: add_stamp_q(hdr, 4'h2);
			2: begin add_stamp_q(hdr, 4'h3); add_stamp_q(hdr, 4'h1); end
			default: hdr.push_back(8'($urandom()));
		endcase
		hlen = hdr.size() + body;
		add_start(id, 16'(hlen));
		foreach (hdr[k]) pkt.push_back(hdr[k]);
		repeat (body) pkt.push_back(8'($urandom()));
	endfunction

	function automatic logic [7:0] pick_id();
		case ($urandom_range(0, 7))
			0: return 8'hbd;
			1: return 8'hc0 | (8'($urandom()) & 8'h1f);
			2: return 8'he0 | (8'($urandom()) & 8'h0f);
			3: return 8'hfd;
			4: return 8'hbe;
			5: return 8'hbc | (8'($urandom()) & 8'h03);
			6: return 8'hf0 | (8'($urandom()) & 8'h0f);
			default: return 8'hc0 | (8'($urandom()) & 8'h3f);
		endcase
	endfunction

	task automatic random_packet();
		logic [7:0] id;
		int body;
		id = pick_id();
		body = $urandom_range(0, 6);
		if (id inside {8'hbc, 8'hbe, 8'hbf, 8'hf0, 8'hf1, 8'hf2, 8'hf8, 8'hff}) begin
			add_start(id, ($urandom_range(0, 5) == 0) ? 16'd0 : 16'(body));
			repeat (body) pkt.push_back(8'($urandom()));
		end else if ($urandom_range(0, 2) == 0 && !(id inside {8'hbd, 8'hfd})) begin
			build_mpeg1(id, body);
		end else begin
			build_mpeg2(id, body, $urandom_range(0, 4) != 0);
		end
		// occasional zero length field, a corrupted byte, short runs of noise and a flush
		if ($urandom_range(0, 9) == 0) begin
			pkt[4] = 0;
			pkt[5] = 0;
		end
		if ($urandom_range(0, 6) == 0)
			pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom());
		send_packet();
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 4)) send_byte(0, 8'($urandom()));
		if ($urandom_range(0, 7) == 0)
			send_byte(1, 8'($urandom()));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: stream id kinds, extreme bytes, flush, length extremes
		send_byte(0, 8'hff);
		send_byte(0, 8'h00);
		send_byte(1, 8'hff);
		add_start(8'hbe, 16'd2); pkt.push_back(8'haa); pkt.push_back(8'h55); send_packet();
		add_start(8'hbc, 16'd1); pkt.push_back(8'hff); send_packet();
		add_start(8'hc0, 16'd0); send_packet();
		add_start(8'he0, 16'hffff); pkt.push_back(8'h0f); send_packet();
		send_byte(0, 8'h00); send_byte(1, 8'h00);
		build_mpeg2(8'hbd, 2, 1); send_packet();
		drain();
		write_cfg(1);
		add_start(8'hc0, 16'd0); pkt.push_back(8'h0f); pkt.push_back(8'h77); send_packet();
		send_byte(1, 8'h00);
		drain();
		write_cfg(0);

		while (sent < 400)
			random_packet();
		drain();
		write_cfg(1);
		while (sent < 620)
			random_packet();
		send_byte(1, 8'h00);
		// hold-off until all results are in
		drain();
		write_cfg(0);
		quiet = 1;
		while (sent < 730)
			random_packet();
		drain();

		$display("%0d bytes sent: %0d payload, %0d headers done, %0d skipped, %0d sync losses",
			sent, n_payload, n_header_done, n_skipped, n_lost);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
